// ===== hdl/mvcrc_pkg.sv =====
`default_nettype none

package mvcrc_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_AW = 2;

    localparam logic [CRC_W-1:0] POLY_IEEE_REF = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] POLY_CRC32C   = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] POLY_MSB      = 32'h04C1_1DB7;

    localparam logic [CRC_W-1:0] START_RESET   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        VAR_REFL_INV = 2'd0,   // reflected, programmable poly, inverted out
        VAR_C_INV    = 2'd1,   // reflected CRC32C, inverted out
        VAR_MSB_RAW  = 2'd2,   // MSB-first 0x04C11DB7, raw out
        VAR_REFL_RAW = 2'd3    // reflected IEEE, raw out
    } crc_variant_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_VARIANT = 2'd0,
        REG_START   = 2'd1,
        REG_POLY    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        crc_variant_t     variant;
        logic [CRC_W-1:0] start_value;
        logic [CRC_W-1:0] reflected_poly;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/mvcrc_cfg.sv =====
`default_nettype none

// Configuration register file, write only.
module mvcrc_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mvcrc_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [mvcrc_pkg::CRC_W-1:0]     cfg_wr_data,
    output mvcrc_pkg::cfg_t                      cfg
);

    mvcrc_pkg::cfg_t cfg_reg;
    mvcrc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (mvcrc_pkg::cfg_index_t'(cfg_addr))
                mvcrc_pkg::REG_VARIANT: begin
                    cfg_next.variant = mvcrc_pkg::crc_variant_t'(cfg_wr_data[1:0]);
                end
                mvcrc_pkg::REG_START: begin
                    cfg_next.start_value = cfg_wr_data;
                end
                mvcrc_pkg::REG_POLY: begin
                    cfg_next.reflected_poly = cfg_wr_data;
                end
                default: begin
                    cfg_next = cfg_reg;   // unmapped index, ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.variant        <= mvcrc_pkg::VAR_REFL_INV;
            cfg_reg.start_value    <= mvcrc_pkg::START_RESET;
            cfg_reg.reflected_poly <= mvcrc_pkg::POLY_IEEE_REF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/mvcrc_fold.sv =====
`default_nettype none

// One byte folded into the CRC: eight shift/xor steps, picked by variant.
module mvcrc_fold (
    input  wire mvcrc_pkg::cfg_t                 cfg,
    input  wire logic                            first,
    input  wire logic [mvcrc_pkg::CRC_W-1:0]     crc_prev,
    input  wire logic [mvcrc_pkg::BYTE_W-1:0]    data,
    output logic      [mvcrc_pkg::CRC_W-1:0]     crc_next,
    output logic      [mvcrc_pkg::CRC_W-1:0]     result
);

    logic [mvcrc_pkg::CRC_W-1:0] crc_in;
    logic [mvcrc_pkg::CRC_W-1:0] refl_poly;
    logic [mvcrc_pkg::CRC_W-1:0] refl_crc;
    logic [mvcrc_pkg::CRC_W-1:0] msb_crc;

    assign crc_in = first ? cfg.start_value : crc_prev;

    always_comb begin
        unique case (cfg.variant)
            mvcrc_pkg::VAR_REFL_INV: refl_poly = cfg.reflected_poly;
            mvcrc_pkg::VAR_C_INV:    refl_poly = mvcrc_pkg::POLY_CRC32C;
            default:                 refl_poly = mvcrc_pkg::POLY_IEEE_REF;
        endcase
    end

    // LSB-first path
    always_comb begin
        refl_crc = crc_in ^ {{(mvcrc_pkg::CRC_W-mvcrc_pkg::BYTE_W){1'b0}}, data};
        for (int k = 0; k < mvcrc_pkg::BYTE_W; k++) begin
            refl_crc = refl_crc[0] ? ((refl_crc >> 1) ^ refl_poly) : (refl_crc >> 1);
        end
    end

    // MSB-first path
    always_comb begin
        msb_crc = crc_in ^ {data, {(mvcrc_pkg::CRC_W-mvcrc_pkg::BYTE_W){1'b0}}};
        for (int k = 0; k < mvcrc_pkg::BYTE_W; k++) begin
            msb_crc = msb_crc[mvcrc_pkg::CRC_W-1] ?
                      ((msb_crc << 1) ^ mvcrc_pkg::POLY_MSB) : (msb_crc << 1);
        end
    end

    always_comb begin
        unique case (cfg.variant)
            mvcrc_pkg::VAR_REFL_INV,
            mvcrc_pkg::VAR_C_INV: begin
                crc_next = refl_crc;
                result   = ~refl_crc;
            end
            mvcrc_pkg::VAR_MSB_RAW: begin
                crc_next = msb_crc;
                result   = msb_crc;
            end
            default: begin
                crc_next = refl_crc;
                result   = refl_crc;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/multi_variant_crc32_engine.sv =====
// Channel   | Direction | Ports                                             | Handshake
// ----------+-----------+---------------------------------------------------+-------------
// input     | in        | s_data_byte, s_first_byte, s_last_byte            | s_valid/s_ready
// result    | out       | m_crc_result                                      | m_valid/m_ready
// config    | in        | cfg_addr, cfg_wr_data                             | cfg_wr_en
//
// One byte per cycle while no held result blocks a last-marked byte: a request is
// registered, folded (eight shift/xor steps) and the CRC register updated as it retires.
// Only bytes marked last produce a result request; the others retire without one.
// Reset (aresetn, synchronous) clears both valid flags and the running CRC, and
// loads the register defaults (variant 0, start 0xFFFFFFFF, poly 0xEDB88320).
// A held result blocks only a last-marked byte behind it; s_ready then follows m_ready.
`default_nettype none

module multi_variant_crc32_engine (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [mvcrc_pkg::BYTE_W-1:0]    s_data_byte,
    input  wire logic                            s_first_byte,
    input  wire logic                            s_last_byte,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [mvcrc_pkg::CRC_W-1:0]     m_crc_result,

    input  wire logic                            cfg_wr_en,
    input  wire logic [mvcrc_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [mvcrc_pkg::CRC_W-1:0]     cfg_wr_data
);

    mvcrc_pkg::cfg_t cfg;

    // input stage
    logic                            s1_valid_reg, s1_valid_next;
    logic [mvcrc_pkg::BYTE_W-1:0]    s1_data_reg;
    logic                            s1_first_reg;
    logic                            s1_last_reg;

    // running CRC and result stage
    logic [mvcrc_pkg::CRC_W-1:0]     crc_reg, crc_next;
    logic                            m_valid_reg, m_valid_next;
    logic [mvcrc_pkg::CRC_W-1:0]     m_result_reg;

    logic [mvcrc_pkg::CRC_W-1:0]     fold_crc;
    logic [mvcrc_pkg::CRC_W-1:0]     fold_result;

    logic                            s_accept;
    logic                            s1_advance;   // input stage retires this cycle
    logic                            out_load;     // result register takes a request

    mvcrc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    mvcrc_fold u_fold (
        .cfg      (cfg),
        .first    (s1_first_reg),
        .crc_prev (crc_reg),
        .data     (s1_data_reg),
        .crc_next (fold_crc),
        .result   (fold_result)
    );

    // A non-last byte never needs the result slot; a last byte needs it free
    // or draining this cycle.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !m_valid_reg || m_ready);
    assign out_load   = s1_advance && s1_last_reg;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end

        crc_next = s1_advance ? fold_crc : crc_reg;

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            crc_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            crc_reg      <= crc_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_data_reg  <= s_data_byte;
            s1_first_reg <= s_first_byte;
            s1_last_reg  <= s_last_byte;
        end
        if (out_load) begin
            m_result_reg <= fold_result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_crc_result = m_result_reg;

`ifndef SYNTHESIS
    // stalled input stage keeps its byte
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_advance) |=>
            (s1_valid_reg && $stable(s1_data_reg) && $stable(s1_first_reg)
             && $stable(s1_last_reg)))
        else $error("input stage lost or changed a held request");

    // CRC register moves only when a byte retires
    a_crc_still: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_advance |=> $stable(crc_reg))
        else $error("running CRC changed without a byte");

    // a pending last byte behind a held result blocks the input
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_last_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while result slot blocked");

    // a result appears only from a retiring last byte
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && !out_load |=> !m_valid_reg)
        else $error("result request without a last byte");
`endif

endmodule

`default_nettype wire
